// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the ray/box test RTL.
// Each macro expects clk and rst in scope of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset
`define RAB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset
`define RAB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/rab_pkg.sv =====
// Shared constants and types for the ray/box slab test.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package rab_pkg;
  localparam int COORD_BITS = 32;
  localparam int REL_W      = COORD_BITS + 1;
  localparam int NUM_W      = COORD_BITS + 2;
  localparam int UN_W       = COORD_BITS + 1;
  localparam int EXT_W      = COORD_BITS - 1;
  localparam int FRAC       = 16;
  localparam int Q_BITS     = 32;
  localparam int LANE_LAT   = Q_BITS + 3;
  localparam int THR_W      = 16;
  localparam int AXES       = 3;

  localparam logic [Q_BITS-1:0] T_MAX = {1'b0, {(Q_BITS-1){1'b1}}};
  localparam logic [Q_BITS-1:0] T_MIN = {1'b1, {(Q_BITS-1){1'b0}}};

  // Register byte address of parallel_threshold
  localparam logic [2:0] ADDR_THRESHOLD = 3'd0;

  typedef logic [Q_BITS-1:0] tval_t;

  // Per-item flags that ride alongside the divider lanes
  typedef struct packed {
    logic            vld;
    logic [AXES-1:0] par;
    logic [AXES-1:0] pmiss;
  } side_t;
endpackage

// ===== rtl/core/rab_div_lane.sv =====
// One pipelined Q16.16 divider lane: (num * 2^16) / den, truncated, saturated.
// One quotient bit per stage; depends on rab_pkg.
`timescale 1ns / 1ps
module rab_div_lane (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [rab_pkg::NUM_W-1:0] num,
  input  logic signed [rab_pkg::COORD_BITS-1:0] den,
  output rab_pkg::tval_t                   t
);
  localparam int DW = rab_pkg::COORD_BITS;
  localparam int QB = rab_pkg::Q_BITS;
  localparam int UW = rab_pkg::UN_W;
  localparam int FR = rab_pkg::FRAC;

  logic [UW-1:0] un0;
  logic [DW-1:0] ud0;
  logic          neg0;

  logic [DW-1:0] rem  [0:QB];
  logic [QB-1:0] lowb [0:QB];
  logic [QB-1:0] quo  [0:QB];
  logic [DW-1:0] ud   [0:QB];
  logic          neg  [0:QB];
  logic          ovf  [0:QB];

  logic [rab_pkg::NUM_W-1:0] num_abs;
  logic [DW-1:0]             den_abs;

  // Take magnitudes and the result sign
  assign num_abs = num[rab_pkg::NUM_W-1] ? -num : num;
  assign den_abs = den[DW-1] ? -den : den;

  always_ff @(posedge clk) begin
    if (en) begin
      un0  <= num_abs[UW-1:0];
      ud0  <= den_abs;
      neg0 <= num[rab_pkg::NUM_W-1] ^ den[DW-1];
    end
  end

  // Seed the remainder with the integer part and flag quotients of 2^32 or more
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= DW'(un0[UW-1:FR]);
      lowb[0] <= {un0[FR-1:0], {(QB-FR){1'b0}}};
      quo[0]  <= '0;
      ud[0]   <= ud0;
      neg[0]  <= neg0;
      ovf[0]  <= DW'(un0[UW-1:FR]) >= ud0;
    end
  end

  // Restoring division, one bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_bit
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;
    assign trial = {rem[k], lowb[k][QB-1]};
    assign diff  = trial - {1'b0, ud[k]};
    assign ge    = trial >= {1'b0, ud[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        lowb[k+1] <= {lowb[k][QB-2:0], 1'b0};
        quo[k+1]  <= {quo[k][QB-2:0], ge};
        ud[k+1]   <= ud[k];
        neg[k+1]  <= neg[k];
        ovf[k+1]  <= ovf[k];
      end
    end
  end

  // Apply sign and saturate to 32 bits
  always_ff @(posedge clk) begin
    if (en) begin
      if (ovf[QB] || quo[QB][QB-1]) begin
        t <= neg[QB] ? rab_pkg::T_MIN : rab_pkg::T_MAX;
      end else begin
        t <= neg[QB] ? -quo[QB] : quo[QB];
      end
    end
  end
endmodule

// ===== rtl/core/rab_merge.sv =====
// Merge stage: combines the per-axis slab intervals into hit and entry distance.
// Depends on rab_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rab_merge (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  rab_pkg::side_t        side,
  input  rab_pkg::tval_t        t1 [rab_pkg::AXES],
  input  rab_pkg::tval_t        t2 [rab_pkg::AXES],
  output logic                  valid,
  output logic                  hit,
  output logic signed [31:0]    distance
);
  localparam int AX = rab_pkg::AXES;

  rab_pkg::tval_t lo [AX];
  rab_pkg::tval_t hi [AX];
  rab_pkg::side_t side1;

  rab_pkg::tval_t entry2, exit2;
  logic           vld2, pmiss2;

  rab_pkg::tval_t lo_m [AX];
  rab_pkg::tval_t hi_m [AX];
  rab_pkg::tval_t mx01, mn01, entry_next, exit_next;
  logic           miss;

  // Order each axis pair
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < AX; a++) begin
        if ($signed(t1[a]) < $signed(t2[a])) begin
          lo[a] <= t1[a];
          hi[a] <= t2[a];
        end else begin
          lo[a] <= t2[a];
          hi[a] <= t1[a];
        end
      end
    end
  end

  // Drop parallel axes from the interval
  always_comb begin
    for (int a = 0; a < AX; a++) begin
      lo_m[a] = side1.par[a] ? rab_pkg::T_MIN : lo[a];
      hi_m[a] = side1.par[a] ? rab_pkg::T_MAX : hi[a];
    end
    mx01       = ($signed(lo_m[0]) > $signed(lo_m[1])) ? lo_m[0] : lo_m[1];
    entry_next = ($signed(lo_m[2]) > $signed(mx01)) ? lo_m[2] : mx01;
    mn01       = ($signed(hi_m[0]) < $signed(hi_m[1])) ? hi_m[0] : hi_m[1];
    exit_next  = ($signed(hi_m[2]) < $signed(mn01)) ? hi_m[2] : mn01;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      entry2 <= entry_next;
      exit2  <= exit_next;
      pmiss2 <= |side1.pmiss;
    end
  end

  assign miss = pmiss2 || ($signed(entry2) > $signed(exit2)) || exit2[31];

  // Valid flags, side flags and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      side1.vld <= 1'b0;
      vld2      <= 1'b0;
      valid     <= 1'b0;
    end else if (en) begin
      side1     <= side;
      vld2      <= side1.vld;
      valid     <= vld2;
      hit       <= !miss;
      distance  <= miss ? '0 : $signed(entry2);
    end
  end

  `RAB_ASSERT_NOW(a_miss_zero, valid && !hit, distance == 0)
  `RAB_ASSERT_NEXT(a_out_follows, en && vld2, valid)
endmodule

// ===== rtl/core/ray_aabb_slab_intersect.sv =====
// Pipeline: 40 register stages from a request to rsp_valid (2 setup stages,
// 35-stage divider lanes with one quotient bit per stage, 3 merge stages).
// Throughput: one transaction per cycle; the whole pipeline holds while a
// result waits on rsp_ready. Reset (rst, synchronous) clears all valid flags
// and sets parallel_threshold to 0.
// Depends on rab_pkg, rab_div_lane, rab_merge.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ray_aabb_slab_intersect (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic signed [rab_pkg::COORD_BITS-1:0] origin_x,
  input  logic signed [rab_pkg::COORD_BITS-1:0] origin_y,
  input  logic signed [rab_pkg::COORD_BITS-1:0] origin_z,
  input  logic signed [rab_pkg::COORD_BITS-1:0] dir_x,
  input  logic signed [rab_pkg::COORD_BITS-1:0] dir_y,
  input  logic signed [rab_pkg::COORD_BITS-1:0] dir_z,
  input  logic signed [rab_pkg::COORD_BITS-1:0] center_x,
  input  logic signed [rab_pkg::COORD_BITS-1:0] center_y,
  input  logic signed [rab_pkg::COORD_BITS-1:0] center_z,
  input  logic [rab_pkg::EXT_W-1:0]             half_size_x,
  input  logic [rab_pkg::EXT_W-1:0]             half_size_y,
  input  logic [rab_pkg::EXT_W-1:0]             half_size_z,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic        hit,
  output logic signed [31:0] distance
);
  localparam int AX = rab_pkg::AXES;
  localparam int CB = rab_pkg::COORD_BITS;

  logic [rab_pkg::THR_W-1:0] threshold;
  logic                      adv;
  logic                      cfg_wr;

  logic signed [CB-1:0] org_a [AX];
  logic signed [CB-1:0] dir_a [AX];
  logic signed [CB-1:0] cen_a [AX];
  logic [rab_pkg::EXT_W-1:0] ext_a [AX];

  // Stage 1
  logic signed [rab_pkg::REL_W-1:0] rel1 [AX];
  logic [rab_pkg::EXT_W-1:0]        ext1 [AX];
  logic signed [CB-1:0]             dir1 [AX];
  logic [AX-1:0]                    par1;
  logic                             v1;

  // Stage 2
  logic signed [rab_pkg::NUM_W-1:0] nlo2 [AX];
  logic signed [rab_pkg::NUM_W-1:0] nhi2 [AX];
  logic signed [CB-1:0]             dir2 [AX];
  rab_pkg::side_t                   side2;

  rab_pkg::side_t side_dly [rab_pkg::LANE_LAT];
  rab_pkg::tval_t t1 [AX];
  rab_pkg::tval_t t2 [AX];

  assign org_a = '{origin_x, origin_y, origin_z};
  assign dir_a = '{dir_x, dir_y, dir_z};
  assign cen_a = '{center_x, center_y, center_z};
  assign ext_a = '{half_size_x, half_size_y, half_size_z};

  // Advance the pipeline unless a result is held
  assign adv       = !rsp_valid || rsp_ready;
  assign req_ready = adv;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == rab_pkg::ADDR_THRESHOLD);
  assign prdata = (paddr == rab_pkg::ADDR_THRESHOLD) ? 32'(threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_wr) begin
      threshold <= pwdata[rab_pkg::THR_W-1:0];
    end
  end

  // Relative center and parallel test
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= req_valid;
      for (int a = 0; a < AX; a++) begin
        rel1[a] <= rab_pkg::REL_W'(cen_a[a]) - rab_pkg::REL_W'(org_a[a]);
        ext1[a] <= ext_a[a];
        dir1[a] <= dir_a[a];
        par1[a] <= (dir_a[a][CB-1] ? -dir_a[a] : dir_a[a]) <= CB'(threshold);
      end
    end
  end

  // Slab numerators and parallel-axis miss
  always_ff @(posedge clk) begin
    if (rst) begin
      side2.vld <= 1'b0;
    end else if (adv) begin
      for (int a = 0; a < AX; a++) begin
        nlo2[a] <= rab_pkg::NUM_W'(rel1[a]) - rab_pkg::NUM_W'($signed({1'b0, ext1[a]}));
        nhi2[a] <= rab_pkg::NUM_W'(rel1[a]) + rab_pkg::NUM_W'($signed({1'b0, ext1[a]}));
        dir2[a] <= dir1[a];
        side2.pmiss[a] <= par1[a] &&
          ((rab_pkg::NUM_W'(rel1[a]) < -rab_pkg::NUM_W'($signed({1'b0, ext1[a]}))) ||
           (rab_pkg::NUM_W'(rel1[a]) >  rab_pkg::NUM_W'($signed({1'b0, ext1[a]}))));
      end
      side2.par <= par1;
      side2.vld <= v1;
    end
  end

  // Carry flags alongside the divider lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rab_pkg::LANE_LAT; i++) begin
        side_dly[i].vld <= 1'b0;
      end
    end else if (adv) begin
      side_dly[0] <= side2;
      for (int i = 1; i < rab_pkg::LANE_LAT; i++) begin
        side_dly[i] <= side_dly[i-1];
      end
    end
  end

  // Six divider lanes, two per axis
  for (genvar a = 0; a < AX; a++) begin : g_axis
    rab_div_lane u_div_lo (
      .clk (clk),
      .en  (adv),
      .num (nlo2[a]),
      .den (dir2[a]),
      .t   (t1[a])
    );
    rab_div_lane u_div_hi (
      .clk (clk),
      .en  (adv),
      .num (nhi2[a]),
      .den (dir2[a]),
      .t   (t2[a])
    );
  end

  rab_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .side     (side_dly[rab_pkg::LANE_LAT-1]),
    .t1       (t1),
    .t2       (t2),
    .valid    (rsp_valid),
    .hit      (hit),
    .distance (distance)
  );

  `RAB_ASSERT_NOW(a_ready_rule, 1'b1, req_ready == (!rsp_valid || rsp_ready))
  `RAB_ASSERT_NEXT(a_cfg_write, cfg_wr, threshold == $past(pwdata[rab_pkg::THR_W-1:0]))
  `RAB_ASSERT_NEXT(a_stall_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(side2))
endmodule
